@@ rtl/core/ffwe_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the flagged frame word extractor.
// No dependencies; imported by every module of the block but ffwe_word_ram.
package ffwe_pkg;

   localparam int BYTE_W       = 8;
   localparam int WORD_W       = 16;
   localparam int IDX_W        = 5;
   localparam int WPF_W        = 6;
   localparam int CSR_AW       = 2;
   // word counts and positions inside a frame (MAX_WORDS up to 64)
   localparam int CNT_W        = 7;

   localparam int MAX_WORDS_DEF = 32;
   localparam int RSP_DEPTH_DEF = 4;

   localparam logic [CSR_AW-1:0] CSR_START_FLAG = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_END_FLAG   = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_WORDS      = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_HAS_SEQ    = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0] data_word;
      logic [IDX_W-1:0]  word_index;
      logic              last_word;
   } rsp_item_type;

   // frame handed from front to back when the end flag matches
   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] n;
   } commit_type;

   // drain progress reported by the back end
   typedef struct packed {
      logic             active;
      logic [CNT_W-1:0] next_k;
      logic [CNT_W-1:0] n;
   } drain_type;

endpackage

@@ rtl/core/flagged_frame_word_extractor.sv @@
`timescale 1ns / 1ps
// Once its end byte is taken, the first word of a good frame passes the back
// end's drain state, the buffer read register and the result queue; later
// words follow one per cycle while the queue has room. Bytes go in one per
// cycle; full rises only if a word slot or end byte meets a draining frame.
// Reset (synchronous, active high) clears config to defaults and hunts again.
// Depends on ffwe_pkg, ffwe_front, ffwe_word_ram, ffwe_back, ffwe_rsp_fifo.
module flagged_frame_word_extractor #(
   parameter int MAX_WORDS = ffwe_pkg::MAX_WORDS_DEF,
   parameter int RSP_DEPTH = ffwe_pkg::RSP_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration writes
   input  logic                         csr_wr_en,
   input  logic [ffwe_pkg::CSR_AW-1:0]  csr_index,
   input  logic [ffwe_pkg::BYTE_W-1:0]  csr_wdata,
   // byte input, queue style
   input  logic                         push,
   output logic                         full,
   input  logic [ffwe_pkg::BYTE_W-1:0]  req_rx_byte,
   // word output, queue style
   output logic                         empty,
   input  logic                         pop,
   output logic [ffwe_pkg::WORD_W-1:0]  rsp_data_word,
   output logic [ffwe_pkg::IDX_W-1:0]   rsp_word_index,
   output logic                         rsp_last_word
);
   import ffwe_pkg::*;

   // word buffer address width
   localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int QCW = $clog2(RSP_DEPTH + 1);

   commit_type        commit;
   drain_type         drain;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [WORD_W-1:0] wr_data, rd_data;
   logic              q_push;
   rsp_item_type      q_item, q_head;
   logic [QCW-1:0]    q_count;
   logic              q_pop;

   // Front: holds the config registers, hunts for the start flag, pairs
   // data bytes into words and checks the end flag. A matching end byte
   // hands the frame's word count to the back end as one transaction.
   ffwe_front #(
      .MAX_WORDS (MAX_WORDS),
      .AW        (AW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push),
      .full      (full),
      .rx_byte   (req_rx_byte),
      .drain     (drain),
      .commit    (commit),
      .ram_we    (wr_en),
      .ram_addr  (wr_addr),
      .ram_data  (wr_data)
   );

   // Word buffer indexed by word position in the frame; the front refills a
   // slot only after the back end has issued the read of its old word.
   ffwe_word_ram #(
      .DEPTH (MAX_WORDS),
      .AW    (AW),
      .DW    (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Back: walks the committed frame, one buffer read per cycle while the
   // result queue has room, and tags each word with index and last mark.
   ffwe_back #(
      .AW        (AW),
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .commit   (commit),
      .drain    (drain),
      .ram_re   (rd_en),
      .ram_addr (rd_addr),
      .ram_data (rd_data),
      .q_count  (q_count),
      .q_push   (q_push),
      .q_item   (q_item)
   );

   // Result queue decouples the draining from a stalling consumer.
   assign q_pop = pop && !empty;

   ffwe_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_item (q_item),
      .rd_en   (q_pop),
      .rd_item (q_head),
      .empty   (empty),
      .count   (q_count)
   );

   assign rsp_data_word  = q_head.data_word;
   assign rsp_word_index = q_head.word_index;
   assign rsp_last_word  = q_head.last_word;

endmodule

@@ rtl/core/ffwe_word_ram.sv @@
`timescale 1ns / 1ps
// Word buffer: one write port, one registered read port, read-first.
// Depends on nothing.
module ffwe_word_ram #(
   parameter int DEPTH  = 32,
   parameter int AW     = 5,
   parameter int DW     = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ffwe_front.sv @@
`timescale 1ns / 1ps
// Front end: config registers, start hunt, byte pairing and end check.
// Depends on ffwe_pkg; writes the word buffer, commits frames to the back end.
module ffwe_front #(
   parameter int MAX_WORDS = 32,
   parameter int AW        = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [ffwe_pkg::CSR_AW-1:0]   csr_index,
   input  logic [ffwe_pkg::BYTE_W-1:0]   csr_wdata,
   input  logic                          push,
   output logic                          full,
   input  logic [ffwe_pkg::BYTE_W-1:0]   rx_byte,
   input  ffwe_pkg::drain_type           drain,
   output ffwe_pkg::commit_type          commit,
   output logic                          ram_we,
   output logic [AW-1:0]                 ram_addr,
   output logic [ffwe_pkg::WORD_W-1:0]   ram_data
);
   import ffwe_pkg::*;

   localparam int PW = $clog2(2 * MAX_WORDS + 3);
   localparam logic [CNT_W-1:0] MAXN = CNT_W'(MAX_WORDS);

   logic [BYTE_W-1:0] start_flag_ff, end_flag_ff;
   logic [WPF_W-1:0]  words_ff;
   logic              has_seq_ff;

   logic              collecting_ff, collecting_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [BYTE_W-1:0] hold_ff, hold_in;

   logic [CNT_W-1:0]  wpf_ext, n_eff;
   logic [PW-1:0]     d, two_n;
   logic              seq_skip, data_pos, end_pos, wr_pos, hazard, accept;
   logic [AW-1:0]     w;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_flag_ff <= '0;
         end_flag_ff   <= '0;
         words_ff      <= WPF_W'(1);
         has_seq_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_FLAG: start_flag_ff <= csr_wdata;
            CSR_END_FLAG:   end_flag_ff   <= csr_wdata;
            CSR_WORDS:      words_ff      <= csr_wdata[WPF_W-1:0];
            CSR_HAS_SEQ:    has_seq_ff    <= csr_wdata[0];
         endcase
      end
   end

   always_comb begin
      wpf_ext = CNT_W'(words_ff);
      if (wpf_ext == '0) begin
         n_eff = CNT_W'(1);
      end else if (wpf_ext > MAXN) begin
         n_eff = MAXN;
      end else begin
         n_eff = wpf_ext;
      end
   end

   assign two_n    = PW'({n_eff, 1'b0});
   assign seq_skip = has_seq_ff && (pos_ff == PW'(1));
   assign d        = pos_ff - PW'(1) - PW'(has_seq_ff);
   assign data_pos = d < two_n;
   assign end_pos  = collecting_ff && !seq_skip && !data_pos;
   assign wr_pos   = collecting_ff && !seq_skip && data_pos && d[0];
   assign w        = d[AW:1];

   // hold off a word write into a slot the back end has not read yet,
   // and hold off the end byte until the previous frame is fully issued
   assign hazard = drain.active && (end_pos ||
                   (wr_pos && CNT_W'(w) >= drain.next_k && CNT_W'(w) < drain.n));
   assign full   = hazard;
   assign accept = push && !full;

   always_comb begin
      collecting_in = collecting_ff;
      pos_in        = pos_ff;
      hold_in       = hold_ff;
      ram_we        = 1'b0;
      commit.valid  = 1'b0;
      commit.n      = n_eff;
      if (accept) begin
         if (!collecting_ff) begin
            if (rx_byte == start_flag_ff) begin
               collecting_in = 1'b1;
               pos_in        = PW'(1);
            end
         end else begin
            pos_in = pos_ff + PW'(1);
            if (seq_skip) begin
               pos_in = pos_ff + PW'(1);
            end else if (data_pos) begin
               if (!d[0]) begin
                  hold_in = rx_byte;
               end else begin
                  ram_we = 1'b1;
               end
            end else begin
               collecting_in = 1'b0;
               pos_in        = '0;
               commit.valid  = (rx_byte == end_flag_ff);
            end
         end
      end
   end

   assign ram_addr = w;
   assign ram_data = {hold_ff, rx_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         pos_ff        <= '0;
         hold_ff       <= '0;
      end else begin
         collecting_ff <= collecting_in;
         pos_ff        <= pos_in;
         hold_ff       <= hold_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ram_we && drain.active) |->
         (CNT_W'(ram_addr) < drain.next_k || CNT_W'(ram_addr) >= drain.n))
      else $error("word write into an unread slot of the draining frame");

   a_commit_idle: assert property (@(posedge clock) disable iff (reset)
      commit.valid |-> !drain.active)
      else $error("frame committed while the previous one still drains");

endmodule

@@ rtl/core/ffwe_rsp_fifo.sv @@
`timescale 1ns / 1ps
// Result queue holding finished words until the consumer pops them.
// Depends on ffwe_pkg for the result item type.
module ffwe_rsp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  ffwe_pkg::rsp_item_type         wr_item,
   input  logic                           rd_en,
   output ffwe_pkg::rsp_item_type         rd_item,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     count
);
   import ffwe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   rsp_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      cnt_in = cnt_ff + CW'(wr_en) - CW'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign rd_item = mem_ff[rd_ptr_ff];
   assign empty   = (cnt_ff == '0);
   assign count   = cnt_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !rd_en) |-> (cnt_ff < CW'(DEPTH)))
      else $error("result queue overflow");

endmodule

@@ rtl/core/ffwe_back.sv @@
`timescale 1ns / 1ps
// Back end: drains a committed frame from the word buffer, tagging index and
// last mark, one word a cycle while the queue has room. Depends on ffwe_pkg.
module ffwe_back #(
   parameter int AW        = 5,
   parameter int RSP_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ffwe_pkg::commit_type               commit,
   output ffwe_pkg::drain_type                drain,
   output logic                               ram_re,
   output logic [AW-1:0]                      ram_addr,
   input  logic [ffwe_pkg::WORD_W-1:0]        ram_data,
   input  logic [$clog2(RSP_DEPTH+1)-1:0]     q_count,
   output logic                               q_push,
   output ffwe_pkg::rsp_item_type             q_item
);
   import ffwe_pkg::*;

   localparam int CW = $clog2(RSP_DEPTH + 1);

   logic             active_ff, active_in;
   logic [CNT_W-1:0] k_ff, k_in, n_ff, n_in;
   logic             infl_ff;
   logic [CNT_W-1:0] infl_k_ff;
   logic             infl_last_ff;
   logic             issue, is_last;

   // a read in flight already owns one queue slot
   assign issue   = active_ff && ((q_count + CW'(infl_ff)) < CW'(RSP_DEPTH));
   assign is_last = (k_ff == n_ff - CNT_W'(1));

   always_comb begin
      active_in = active_ff;
      k_in      = k_ff;
      n_in      = n_ff;
      if (commit.valid) begin
         active_in = 1'b1;
         k_in      = '0;
         n_in      = commit.n;
      end else if (issue) begin
         k_in = k_ff + CNT_W'(1);
         if (is_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         k_ff      <= '0;
         n_ff      <= '0;
         infl_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         k_ff      <= k_in;
         n_ff      <= n_in;
         infl_ff   <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         infl_k_ff    <= k_ff;
         infl_last_ff <= is_last;
      end
   end

   assign ram_re   = issue;
   assign ram_addr = k_ff[AW-1:0];

   assign q_push            = infl_ff;
   assign q_item.data_word  = ram_data;
   assign q_item.word_index = IDX_W'(infl_k_ff);
   assign q_item.last_word  = infl_last_ff;

   assign drain.active = active_ff;
   assign drain.next_k = k_ff;
   assign drain.n      = n_ff;

   a_drain_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (n_ff != '0 && k_ff < n_ff))
      else $error("drain index out of frame range");

endmodule
